@@ sv/mtsv_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and helper functions of the morph-then-skin vertex unit.
package mtsv_pkg;

   localparam int MAX_BONES        = 256;
   localparam int MAX_CHANNELS     = 16;
   localparam int EXPLICIT_WEIGHTS = 3;

   localparam int MAT_ROWS = MAX_BONES * 4;
   localparam int MAT_AW   = (MAT_ROWS > 1) ? $clog2(MAT_ROWS) : 1;
   localparam int CH_AW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   localparam int ONE_Q16    = 65536;
   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 17;
   localparam int ITER_W     = 5;

   typedef logic signed [31:0] q16_type;
   typedef logic signed [17:0] unit_type;
   typedef logic [16:0]        weight_type;

   typedef enum logic [1:0] {
      OP_MAT_ROW,
      OP_CHAN_WEIGHT,
      OP_MORPH_DELTA,
      OP_VERTEX
   } op_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_MORPH_MUL,
      ST_MORPH_ACC,
      ST_SQ_MUL,
      ST_SQ_ACC,
      ST_SQRT,
      ST_DIV_START,
      ST_DIV,
      ST_BONE_CHK,
      ST_ROW_RD,
      ST_MAT_MUL,
      ST_MAT_ACC,
      ST_TRANS,
      ST_W_MUL,
      ST_W_ACC,
      ST_FINAL,
      ST_OUT
   } state_type;

   function automatic q16_type sat32(input logic signed [65:0] v);
      if (v > 66'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -66'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic weight_type clamp_w(input logic [16:0] w);
      if (w > 17'(ONE_Q16)) begin
         return 17'(ONE_Q16);
      end
      return w;
   endfunction

endpackage

@@ sv/mtsv_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for vertex items and skinned results.
interface mtsv_req_if;
   logic                    valid;
   logic                    ready;
   logic [1:0]              op;
   logic [9:0]              slot;
   logic signed [31:0]      px;
   logic signed [31:0]      py;
   logic signed [31:0]      pz;
   logic signed [31:0]      nx_in;
   logic signed [31:0]      ny_in;
   logic signed [31:0]      nz_in;
   logic [16:0]             weight_a;
   logic [16:0]             weight_b;
   logic [16:0]             weight_c;
   logic [31:0]             bone_indices;

   modport source (output valid, op, slot, px, py, pz, nx_in, ny_in, nz_in,
                   weight_a, weight_b, weight_c, bone_indices, input ready);
   modport sink (input valid, op, slot, px, py, pz, nx_in, ny_in, nz_in,
                 weight_a, weight_b, weight_c, bone_indices, output ready);
endinterface

interface mtsv_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] out_x;
   logic signed [31:0] out_y;
   logic signed [31:0] out_z;
   logic signed [17:0] out_nx;
   logic signed [17:0] out_ny;
   logic signed [17:0] out_nz;

   modport source (output valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                   input ready);
   modport sink (input valid, out_x, out_y, out_z, out_nx, out_ny, out_nz,
                 output ready);
endinterface

@@ sv/morph_then_skin_vertex_unit.sv @@
`timescale 1ns / 1ps
// Matrix row load and channel weight items are written from the idle state; a morph delta multiplies and accumulates.
// A vertex is worked through one shared 33x33 multiplier,
// a bit-serial square root (32 steps) and a bit-serial divider (17 steps per component).
// The next item is taken once the result sits in the output register.
// Synchronous reset clears the sequencer, channel weights and morph sums; the bone
// matrix memory is not cleared.
module morph_then_skin_vertex_unit (
   input logic        clock,
   input logic        reset,
   mtsv_req_if.sink   req_chan,
   mtsv_rsp_if.source rsp_chan
);

   localparam int E = mtsv_pkg::EXPLICIT_WEIGHTS;

   mtsv_pkg::state_type state_ff, state_in;
   logic [1:0] comp_ff, comp_in;
   logic       half_ff, half_in;
   logic [1:0] row_ff, row_in;
   logic [1:0] bone_ff, bone_in;
   logic [mtsv_pkg::ITER_W-1:0] iter_ff, iter_in;
   logic       pass_ff, pass_in;

   logic accept;
   logic mat_rd_en;
   logic out_load;

   // item and working registers
   mtsv_pkg::q16_type    sp_ff [3];
   mtsv_pkg::q16_type    vec_ff [3];
   mtsv_pkg::unit_type   nrm_ff [3];
   mtsv_pkg::weight_type w_ff [3];
   mtsv_pkg::weight_type cw_ff;
   logic [31:0]          bidx_ff;
   logic signed [49:0]   tp_ff [3];
   logic signed [49:0]   tn_ff [3];
   logic signed [51:0]   pa_ff [3];
   logic signed [51:0]   na_ff [3];

   mtsv_pkg::weight_type chan_w_ff [mtsv_pkg::MAX_CHANNELS];
   mtsv_pkg::q16_type    mps_ff [3];
   mtsv_pkg::q16_type    mns_ff [3];

   // shared multiplier
   logic signed [32:0] mul_a, mul_b;
   logic signed [65:0] prod_ff;

   // square root and divider
   logic [63:0] ss_ff;
   logic [31:0] root_ff;
   logic [33:0] sq_rem_ff;
   logic [35:0] sq_rem_t, sq_trial;
   logic        sq_ge;
   logic [31:0] drem_ff;
   logic [16:0] numlo_ff;
   logic [16:0] quo_ff;
   logic        neg_ff;
   logic [32:0] div_t;
   logic        div_ge;
   logic [16:0] quo_next;
   logic [31:0] vec_mag;
   logic        len_zero;
   logic        norm_comp_done;

   // bone selection
   logic [18:0]          w_sum;
   logic signed [19:0]   rest_s;
   mtsv_pkg::weight_type cur_w;
   logic                 bone_act;
   logic [7:0]           bone_sel;
   logic                 bone_ok;
   logic [mtsv_pkg::MAT_AW-1:0] rd_addr;

   // matrix memory, one row of three columns per entry
   logic [95:0]        mat_mem [mtsv_pkg::MAT_ROWS];
   logic [95:0]        mat_rd_ff;
   mtsv_pkg::q16_type  mat_m [3];

   logic                        slot_mat_ok;
   logic                        slot_ch_ok;
   logic [mtsv_pkg::CH_AW-1:0]  ch_idx;

   logic                 rsp_valid_ff;
   mtsv_pkg::q16_type    out_x_ff, out_y_ff, out_z_ff;
   mtsv_pkg::unit_type   out_nx_ff, out_ny_ff, out_nz_ff;

   assign accept      = req_chan.valid && req_chan.ready;
   assign slot_mat_ok = int'(req_chan.slot) < mtsv_pkg::MAT_ROWS;
   assign slot_ch_ok  = int'(req_chan.slot) < mtsv_pkg::MAX_CHANNELS;
   assign ch_idx      = req_chan.slot[mtsv_pkg::CH_AW-1:0];

   // weight of the current bone; the implicit bone takes what the explicit ones leave
   always_comb begin
      w_sum = '0;
      for (int j = 0; j < E; j++) begin
         w_sum = w_sum + 19'(w_ff[j]);
      end
      rest_s = 20'sd65536 - $signed({1'b0, w_sum});
      cur_w  = rest_s[16:0];
      for (int j = 0; j < E; j++) begin
         if (bone_ff == 2'(j)) begin
            cur_w = w_ff[j];
         end
      end
      bone_act = (bone_ff < 2'(E)) ? (cur_w != '0) : (rest_s > 20'sd0);
      bone_sel = (bone_ff < 2'(E)) ? bidx_ff[8*bone_ff +: 8] : bidx_ff[31:24];
      bone_ok  = int'(bone_sel) < mtsv_pkg::MAX_BONES;
      rd_addr  = mtsv_pkg::MAT_AW'({bone_sel, row_ff});
      for (int c = 0; c < 3; c++) begin
         mat_m[c] = bone_ok ? mat_rd_ff[32*c +: 32] : '0;
      end
   end

   // square root and divide steps
   always_comb begin
      sq_rem_t = {sq_rem_ff, ss_ff[63:62]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_ge    = sq_rem_t >= sq_trial;
      div_t    = {drem_ff, numlo_ff[16]};
      div_ge   = div_t >= {1'b0, root_ff};
      quo_next = {quo_ff[15:0], div_ge};
      vec_mag  = vec_ff[comp_ff][31] ? 32'(-vec_ff[comp_ff]) : vec_ff[comp_ff];
      len_zero = root_ff == '0;
      norm_comp_done =
         ((state_ff == mtsv_pkg::ST_DIV) &&
          (iter_ff == mtsv_pkg::ITER_W'(mtsv_pkg::DIV_STEPS - 1))) ||
         ((state_ff == mtsv_pkg::ST_DIV_START) && len_zero);
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         mtsv_pkg::ST_MORPH_MUL: begin
            mul_a = half_ff ? 33'(vec_ff[comp_ff]) : 33'(sp_ff[comp_ff]);
            mul_b = {16'b0, cw_ff};
         end
         mtsv_pkg::ST_SQ_MUL: begin
            mul_a = 33'(vec_ff[comp_ff]);
            mul_b = 33'(vec_ff[comp_ff]);
         end
         mtsv_pkg::ST_MAT_MUL: begin
            mul_a = half_ff ? 33'(nrm_ff[row_ff]) : 33'(sp_ff[row_ff]);
            mul_b = 33'(mat_m[comp_ff]);
         end
         mtsv_pkg::ST_W_MUL: begin
            mul_a = half_ff ? 33'(mtsv_pkg::sat32(66'(tn_ff[comp_ff])))
                            : 33'(mtsv_pkg::sat32(66'(tp_ff[comp_ff])));
            mul_b = {16'b0, cur_w};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mtsv_pkg::ST_IDLE: begin
            if (accept) begin
               case (mtsv_pkg::op_type'(req_chan.op))
                  mtsv_pkg::OP_MORPH_DELTA: state_in = mtsv_pkg::ST_MORPH_MUL;
                  mtsv_pkg::OP_VERTEX:      state_in = mtsv_pkg::ST_SQ_MUL;
                  default:                  state_in = mtsv_pkg::ST_IDLE;
               endcase
            end
         end
         mtsv_pkg::ST_MORPH_MUL: state_in = mtsv_pkg::ST_MORPH_ACC;
         mtsv_pkg::ST_MORPH_ACC: begin
            state_in = (half_ff && comp_ff == 2'd2) ? mtsv_pkg::ST_IDLE
                                                   : mtsv_pkg::ST_MORPH_MUL;
         end
         mtsv_pkg::ST_SQ_MUL: state_in = mtsv_pkg::ST_SQ_ACC;
         mtsv_pkg::ST_SQ_ACC: begin
            state_in = (comp_ff == 2'd2) ? mtsv_pkg::ST_SQRT : mtsv_pkg::ST_SQ_MUL;
         end
         mtsv_pkg::ST_SQRT: begin
            if (iter_ff == mtsv_pkg::ITER_W'(mtsv_pkg::SQRT_STEPS - 1)) begin
               state_in = mtsv_pkg::ST_DIV_START;
            end
         end
         mtsv_pkg::ST_DIV_START, mtsv_pkg::ST_DIV: begin
            if (norm_comp_done) begin
               if (comp_ff != 2'd2) begin
                  state_in = mtsv_pkg::ST_DIV_START;
               end else if (pass_ff) begin
                  state_in = mtsv_pkg::ST_OUT;
               end else begin
                  state_in = mtsv_pkg::ST_BONE_CHK;
               end
            end else begin
               state_in = mtsv_pkg::ST_DIV;
            end
         end
         mtsv_pkg::ST_BONE_CHK: begin
            state_in = bone_act ? mtsv_pkg::ST_ROW_RD : mtsv_pkg::ST_FINAL;
         end
         mtsv_pkg::ST_ROW_RD: begin
            state_in = (row_ff == 2'd3) ? mtsv_pkg::ST_TRANS : mtsv_pkg::ST_MAT_MUL;
         end
         mtsv_pkg::ST_MAT_MUL: state_in = mtsv_pkg::ST_MAT_ACC;
         mtsv_pkg::ST_MAT_ACC: begin
            state_in = (half_ff && comp_ff == 2'd2) ? mtsv_pkg::ST_ROW_RD
                                                   : mtsv_pkg::ST_MAT_MUL;
         end
         mtsv_pkg::ST_TRANS: state_in = mtsv_pkg::ST_W_MUL;
         mtsv_pkg::ST_W_MUL: state_in = mtsv_pkg::ST_W_ACC;
         mtsv_pkg::ST_W_ACC: begin
            if (half_ff && comp_ff == 2'd2) begin
               state_in = (bone_ff == 2'(E)) ? mtsv_pkg::ST_FINAL : mtsv_pkg::ST_BONE_CHK;
            end else begin
               state_in = mtsv_pkg::ST_W_MUL;
            end
         end
         mtsv_pkg::ST_FINAL: state_in = mtsv_pkg::ST_SQ_MUL;
         mtsv_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = mtsv_pkg::ST_IDLE;
            end
         end
         default: state_in = mtsv_pkg::ST_IDLE;
      endcase
   end

   // counters
   always_comb begin
      comp_in = comp_ff;
      half_in = half_ff;
      row_in  = row_ff;
      bone_in = bone_ff;
      iter_in = iter_ff;
      pass_in = pass_ff;
      case (state_ff)
         mtsv_pkg::ST_IDLE: begin
            comp_in = '0;
            half_in = 1'b0;
            pass_in = 1'b0;
         end
         mtsv_pkg::ST_MORPH_ACC, mtsv_pkg::ST_W_ACC: begin
            if (comp_ff == 2'd2) begin
               comp_in = '0;
               half_in = !half_ff;
               if (half_ff) begin
                  bone_in = bone_ff + 2'd1;
               end
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         mtsv_pkg::ST_MAT_ACC: begin
            if (comp_ff == 2'd2) begin
               comp_in = '0;
               half_in = !half_ff;
               if (half_ff) begin
                  row_in = row_ff + 2'd1;
               end
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         mtsv_pkg::ST_SQ_ACC: begin
            comp_in = (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
            iter_in = '0;
         end
         mtsv_pkg::ST_SQRT: iter_in = iter_ff + 1'b1;
         mtsv_pkg::ST_DIV_START, mtsv_pkg::ST_DIV: begin
            iter_in = (state_ff == mtsv_pkg::ST_DIV) ? iter_ff + 1'b1 : '0;
            if (norm_comp_done) begin
               comp_in = (comp_ff == 2'd2) ? 2'd0 : comp_ff + 2'd1;
               bone_in = '0;
            end
         end
         mtsv_pkg::ST_BONE_CHK: row_in = '0;
         mtsv_pkg::ST_FINAL: begin
            pass_in = 1'b1;
            comp_in = '0;
         end
         default: begin
            comp_in = comp_ff;
         end
      endcase
   end

   // handshake and memory controls
   always_comb begin
      req_chan.ready = state_ff == mtsv_pkg::ST_IDLE;
      mat_rd_en      = state_ff == mtsv_pkg::ST_ROW_RD;
      out_load       = (state_ff == mtsv_pkg::ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtsv_pkg::ST_IDLE;
         comp_ff  <= '0;
         half_ff  <= 1'b0;
         row_ff   <= '0;
         bone_ff  <= '0;
         iter_ff  <= '0;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         comp_ff  <= comp_in;
         half_ff  <= half_in;
         row_ff   <= row_in;
         bone_ff  <= bone_in;
         iter_ff  <= iter_in;
         pass_ff  <= pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && mtsv_pkg::op_type'(req_chan.op) == mtsv_pkg::OP_MAT_ROW &&
          slot_mat_ok) begin
         mat_mem[req_chan.slot[mtsv_pkg::MAT_AW-1:0]] <=
            {req_chan.pz, req_chan.py, req_chan.px};
      end
      if (mat_rd_en) begin
         mat_rd_ff <= mat_mem[rd_addr];
      end
   end

   // channel weights and morph accumulators
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < mtsv_pkg::MAX_CHANNELS; i++) begin
            chan_w_ff[i] <= '0;
         end
         for (int c = 0; c < 3; c++) begin
            mps_ff[c] <= '0;
            mns_ff[c] <= '0;
         end
      end else begin
         if (accept && mtsv_pkg::op_type'(req_chan.op) == mtsv_pkg::OP_CHAN_WEIGHT &&
             slot_ch_ok) begin
            chan_w_ff[ch_idx] <= mtsv_pkg::clamp_w(req_chan.weight_a);
         end
         // drop the sums once a vertex has taken them
         if (accept && mtsv_pkg::op_type'(req_chan.op) == mtsv_pkg::OP_VERTEX) begin
            for (int c = 0; c < 3; c++) begin
               mps_ff[c] <= '0;
               mns_ff[c] <= '0;
            end
         end
         if (state_ff == mtsv_pkg::ST_MORPH_ACC) begin
            if (half_ff) begin
               mns_ff[comp_ff] <= mtsv_pkg::sat32(66'(mns_ff[comp_ff]) + (prod_ff >>> 16));
            end else begin
               mps_ff[comp_ff] <= mtsv_pkg::sat32(66'(mps_ff[comp_ff]) + (prod_ff >>> 16));
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         mtsv_pkg::ST_IDLE: begin
            if (accept) begin
               if (mtsv_pkg::op_type'(req_chan.op) == mtsv_pkg::OP_VERTEX) begin
                  sp_ff[0]  <= mtsv_pkg::sat32(66'(req_chan.px) + 66'(mps_ff[0]));
                  sp_ff[1]  <= mtsv_pkg::sat32(66'(req_chan.py) + 66'(mps_ff[1]));
                  sp_ff[2]  <= mtsv_pkg::sat32(66'(req_chan.pz) + 66'(mps_ff[2]));
                  vec_ff[0] <= mtsv_pkg::sat32(66'(req_chan.nx_in) + 66'(mns_ff[0]));
                  vec_ff[1] <= mtsv_pkg::sat32(66'(req_chan.ny_in) + 66'(mns_ff[1]));
                  vec_ff[2] <= mtsv_pkg::sat32(66'(req_chan.nz_in) + 66'(mns_ff[2]));
               end else begin
                  sp_ff[0]  <= req_chan.px;
                  sp_ff[1]  <= req_chan.py;
                  sp_ff[2]  <= req_chan.pz;
                  vec_ff[0] <= req_chan.nx_in;
                  vec_ff[1] <= req_chan.ny_in;
                  vec_ff[2] <= req_chan.nz_in;
               end
               w_ff[0] <= mtsv_pkg::clamp_w(req_chan.weight_a);
               w_ff[1] <= mtsv_pkg::clamp_w(req_chan.weight_b);
               w_ff[2] <= mtsv_pkg::clamp_w(req_chan.weight_c);
               bidx_ff <= req_chan.bone_indices;
               cw_ff   <= slot_ch_ok ? chan_w_ff[ch_idx] : '0;
               ss_ff   <= '0;
               for (int c = 0; c < 3; c++) begin
                  pa_ff[c] <= '0;
                  na_ff[c] <= '0;
               end
            end
         end
         mtsv_pkg::ST_SQ_ACC: begin
            ss_ff     <= ss_ff + prod_ff[63:0];
            root_ff   <= '0;
            sq_rem_ff <= '0;
         end
         mtsv_pkg::ST_SQRT: begin
            ss_ff     <= ss_ff << 2;
            root_ff   <= {root_ff[30:0], sq_ge};
            sq_rem_ff <= sq_ge ? 34'(sq_rem_t - sq_trial) : 34'(sq_rem_t);
         end
         mtsv_pkg::ST_DIV_START: begin
            drem_ff  <= {1'b0, vec_mag[31:1]};
            numlo_ff <= {vec_mag[0], 16'b0};
            quo_ff   <= '0;
            neg_ff   <= vec_ff[comp_ff][31];
            if (len_zero) begin
               nrm_ff[comp_ff] <= '0;
            end
         end
         mtsv_pkg::ST_DIV: begin
            drem_ff  <= div_ge ? 32'(div_t - {1'b0, root_ff}) : 32'(div_t);
            numlo_ff <= numlo_ff << 1;
            quo_ff   <= quo_next;
            if (norm_comp_done) begin
               nrm_ff[comp_ff] <= neg_ff ? -18'(quo_next) : 18'(quo_next);
            end
         end
         mtsv_pkg::ST_BONE_CHK: begin
            for (int c = 0; c < 3; c++) begin
               tp_ff[c] <= '0;
               tn_ff[c] <= '0;
            end
         end
         mtsv_pkg::ST_MAT_ACC: begin
            if (half_ff) begin
               tn_ff[comp_ff] <= tn_ff[comp_ff] + 50'(prod_ff >>> 16);
            end else begin
               tp_ff[comp_ff] <= tp_ff[comp_ff] + 50'(prod_ff >>> 16);
            end
         end
         mtsv_pkg::ST_TRANS: begin
            for (int c = 0; c < 3; c++) begin
               tp_ff[c] <= tp_ff[c] + 50'(mat_m[c]);
            end
         end
         mtsv_pkg::ST_W_ACC: begin
            if (half_ff) begin
               na_ff[comp_ff] <= na_ff[comp_ff] + 52'(prod_ff);
            end else begin
               pa_ff[comp_ff] <= pa_ff[comp_ff] + 52'(prod_ff);
            end
         end
         mtsv_pkg::ST_FINAL: begin
            for (int c = 0; c < 3; c++) begin
               sp_ff[c]  <= mtsv_pkg::sat32(66'(pa_ff[c] >>> 16));
               vec_ff[c] <= mtsv_pkg::sat32(66'(na_ff[c] >>> 16));
            end
            ss_ff <= '0;
         end
         default: begin
            ss_ff <= ss_ff;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_x_ff  <= sp_ff[0];
         out_y_ff  <= sp_ff[1];
         out_z_ff  <= sp_ff[2];
         out_nx_ff <= nrm_ff[0];
         out_ny_ff <= nrm_ff[1];
         out_nz_ff <= nrm_ff[2];
      end
   end

   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.out_x  = out_x_ff;
   assign rsp_chan.out_y  = out_y_ff;
   assign rsp_chan.out_z  = out_z_ff;
   assign rsp_chan.out_nx = out_nx_ff;
   assign rsp_chan.out_ny = out_ny_ff;
   assign rsp_chan.out_nz = out_nz_ff;

endmodule

@@ sv/mtsv_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for the morph-then-skin vertex unit, bound to the top level.
module mtsv_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [1:0]         req_op,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [17:0] out_nx,
   input logic signed [17:0] out_ny,
   input logic signed [17:0] out_nz
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown right after reset");

   a_unit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (out_nx >= -18'sd65536 && out_nx <= 18'sd65536 &&
                     out_ny >= -18'sd65536 && out_ny <= 18'sd65536 &&
                     out_nz >= -18'sd65536 && out_nz <= 18'sd65536))
      else $error("normal component beyond unit range");

   a_vertex_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_op == mtsv_pkg::OP_VERTEX |=> !req_ready)
      else $error("new item taken while a vertex is in work");

   a_load_quick: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready &&
      (req_op == mtsv_pkg::OP_MAT_ROW || req_op == mtsv_pkg::OP_CHAN_WEIGHT)
      |=> req_ready)
      else $error("table write held the input channel");

endmodule

bind morph_then_skin_vertex_unit mtsv_checker u_mtsv_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .req_op    (req_chan.op),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .out_nx    (rsp_chan.out_nx),
   .out_ny    (rsp_chan.out_ny),
   .out_nz    (rsp_chan.out_nz)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the morph-then-skin vertex unit: directed table plus random stream.
module testbench;

   localparam int  IDLE_LIMIT = 4000;
   localparam int  DRAIN_WAIT = 600;
   localparam int  RANDOM_ITEMS = 1750;
   localparam longint Q_MAX = 64'sd2147483647;
   localparam longint Q_MIN = -64'sd2147483648;

   typedef longint vec3_type [3];

   typedef struct {
      mtsv_pkg::op_type      op;
      logic [9:0]            slot;
      mtsv_pkg::q16_type     px, py, pz;
      mtsv_pkg::q16_type     nx, ny, nz;
      mtsv_pkg::weight_type  wa, wb, wc;
      logic [31:0]           bones;
   } vertex_item_type;

   typedef struct {
      mtsv_pkg::q16_type  x, y, z;
      mtsv_pkg::unit_type nx, ny, nz;
   } skinned_vertex_type;

   typedef struct {
      vertex_item_type    item;
      bit                 typed;
      skinned_vertex_type want;
   } table_row_type;

   logic clock;
   logic reset;

   mtsv_req_if req_chan ();
   mtsv_rsp_if rsp_chan ();

   morph_then_skin_vertex_unit u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state
   mtsv_pkg::q16_type    bone_rows [mtsv_pkg::MAX_BONES*12];
   mtsv_pkg::weight_type chan_weight [mtsv_pkg::MAX_CHANNELS];
   mtsv_pkg::q16_type    morph_pos [3];
   mtsv_pkg::q16_type    morph_nrm [3];

   skinned_vertex_type pending_vertices [$];
   table_row_type      directed_rows [$];
   bit                 row_loaded [mtsv_pkg::MAT_ROWS];
   int                 loaded_bones [$];
   int                 mismatch_count;
   int                 vertices_checked;
   int                 mat_rows_sent, deltas_sent, chan_sets_sent;
   int                 idle_cycles;
   bit                 quiet;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic longint clip32(longint v);
      if (v > Q_MAX) return Q_MAX;
      if (v < Q_MIN) return Q_MIN;
      return v;
   endfunction

   function automatic longint wclamp(logic [16:0] w);
      return (w > 17'(mtsv_pkg::ONE_Q16)) ? longint'(mtsv_pkg::ONE_Q16) : longint'(w);
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned r;
      longint unsigned b;
      r = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic vec3_type unitize(vec3_type n);
      longint unsigned ss;
      longint unsigned a;
      longint len;
      longint q;
      vec3_type o;
      ss = 0;
      for (int i = 0; i < 3; i++) begin
         a = longint'(n[i] < 0 ? -n[i] : n[i]);
         ss = ss + a * a;
      end
      len = longint'(root64(ss));
      for (int i = 0; i < 3; i++) begin
         if (len == 0) begin
            o[i] = 0;
         end else begin
            q = (n[i] * mtsv_pkg::ONE_Q16) / len;
            if (q > mtsv_pkg::ONE_Q16) q = mtsv_pkg::ONE_Q16;
            if (q < -mtsv_pkg::ONE_Q16) q = -mtsv_pkg::ONE_Q16;
            o[i] = q;
         end
      end
      return o;
   endfunction

   function automatic void blend_bone(int bone, longint w, vec3_type p, vec3_type n,
                                      inout vec3_type pa, inout vec3_type na);
      longint tp, tn, m;
      for (int c = 0; c < 3; c++) begin
         tp = 0;
         tn = 0;
         for (int k = 0; k < 3; k++) begin
            m = bone_rows[bone*12 + k*3 + c];
            tp += (p[k] * m) >>> 16;
            tn += (n[k] * m) >>> 16;
         end
         tp = clip32(tp + longint'(bone_rows[bone*12 + 9 + c]));
         tn = clip32(tn);
         pa[c] += tp * w;
         na[c] += tn * w;
      end
   endfunction

   // Advance the predictor by one item; returns 1 when a skinned vertex comes out.
   function automatic bit skin_predict(vertex_item_type it, output skinned_vertex_type r);
      vec3_type p, n, sp, sn, pa, na;
      longint w, total, wl [3];
      int j;
      p = '{longint'(it.px), longint'(it.py), longint'(it.pz)};
      n = '{longint'(it.nx), longint'(it.ny), longint'(it.nz)};
      r = '{default: '0};
      case (it.op)
         mtsv_pkg::OP_MAT_ROW: begin
            bone_rows[it.slot*3]     = it.px;
            bone_rows[it.slot*3 + 1] = it.py;
            bone_rows[it.slot*3 + 2] = it.pz;
            return 1'b0;
         end
         mtsv_pkg::OP_CHAN_WEIGHT: begin
            if (it.slot < mtsv_pkg::MAX_CHANNELS)
               chan_weight[it.slot] = mtsv_pkg::weight_type'(wclamp(it.wa));
            return 1'b0;
         end
         mtsv_pkg::OP_MORPH_DELTA: begin
            if (it.slot < mtsv_pkg::MAX_CHANNELS) begin
               w = chan_weight[it.slot];
               for (int i = 0; i < 3; i++) begin
                  morph_pos[i] =
                     mtsv_pkg::q16_type'(clip32(morph_pos[i] + ((p[i] * w) >>> 16)));
                  morph_nrm[i] =
                     mtsv_pkg::q16_type'(clip32(morph_nrm[i] + ((n[i] * w) >>> 16)));
               end
            end
            return 1'b0;
         end
         default: begin
            for (int i = 0; i < 3; i++) begin
               sp[i] = clip32(p[i] + morph_pos[i]);
               sn[i] = clip32(n[i] + morph_nrm[i]);
               pa[i] = 0;
               na[i] = 0;
            end
            sn = unitize(sn);
            wl = '{wclamp(it.wa), wclamp(it.wb), wclamp(it.wc)};
            total = 0;
            for (j = 0; j < mtsv_pkg::EXPLICIT_WEIGHTS; j++) begin
               if (wl[j] == 0) break;
               blend_bone(int'(it.bones >> (8*j)) & 255, wl[j], sp, sn, pa, na);
               total += wl[j];
            end
            if (j >= mtsv_pkg::EXPLICIT_WEIGHTS && mtsv_pkg::ONE_Q16 - total > 0)
               blend_bone(int'(it.bones[31:24]), mtsv_pkg::ONE_Q16 - total, sp, sn, pa, na);
            for (int i = 0; i < 3; i++) begin
               pa[i] = clip32(pa[i] >>> 16);
               na[i] = clip32(na[i] >>> 16);
            end
            na = unitize(na);
            r.x  = mtsv_pkg::q16_type'(pa[0]);
            r.y  = mtsv_pkg::q16_type'(pa[1]);
            r.z  = mtsv_pkg::q16_type'(pa[2]);
            r.nx = mtsv_pkg::unit_type'(na[0]);
            r.ny = mtsv_pkg::unit_type'(na[1]);
            r.nz = mtsv_pkg::unit_type'(na[2]);
            for (int i = 0; i < 3; i++) begin
               morph_pos[i] = '0;
               morph_nrm[i] = '0;
            end
            return 1'b1;
         end
      endcase
   endfunction

   function automatic vertex_item_type mk(mtsv_pkg::op_type op, int slot, int px, int py,
                                          int pz, int nx, int ny, int nz, int wa, int wb,
                                          int wc, logic [31:0] bones);
      vertex_item_type it;
      it = '{op, 10'(slot), px, py, pz, nx, ny, nz, 17'(wa), 17'(wb), 17'(wc), bones};
      return it;
   endfunction

   function automatic void add_row(vertex_item_type it, bit typed, skinned_vertex_type want);
      directed_rows.push_back('{it, typed, want});
   endfunction

   function automatic void build_directed_table();
      skinned_vertex_type none;
      none = '{default: '0};
      // identity on bone 0, odd matrix with extreme translation on bone 255
      add_row(mk(mtsv_pkg::OP_MAT_ROW, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MAT_ROW, 1, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MAT_ROW, 2, 0, 0, 65536, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MAT_ROW, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MAT_ROW, 1020, 0, 65536, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MAT_ROW, 1021, -65536, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MAT_ROW, 1022, 0, 0, 131072, 0, 0, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MAT_ROW, 1023, 32'sh7fffffff, 32'sh80000000, 100, 0, 0, 0,
                 0, 0, 0, 0), 0, none);
      // identity skin passes the vertex through
      add_row(mk(mtsv_pkg::OP_VERTEX, 0, 65536, 131072, -65536, 0, 0, 65536, 65536, 0, 0, 0),
              1, '{65536, 131072, -65536, 0, 0, 65536});
      // zero-length normal stays zero
      add_row(mk(mtsv_pkg::OP_VERTEX, 0, 0, 0, 0, 0, 0, 0, 65536, 0, 0, 0), 1, none);
      add_row(mk(mtsv_pkg::OP_CHAN_WEIGHT, 0, 0, 0, 0, 0, 0, 0, 131071, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_CHAN_WEIGHT, 15, 0, 0, 0, 0, 0, 0, 32768, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_CHAN_WEIGHT, 16, 0, 0, 0, 0, 0, 0, 1000, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MORPH_DELTA, 0, 65536, 0, 0, 0, 65536, 0, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MORPH_DELTA, 15, 32'sh7fffffff, 32'sh80000000, 7,
                 32'sh80000000, 32'sh7fffffff, -5, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MORPH_DELTA, 3, 12345, -999, 4, 5, 6, 7, 0, 0, 0, 0), 0, none);
      add_row(mk(mtsv_pkg::OP_MORPH_DELTA, 1023, 77777, 1, 2, 3, 4, 5, 0, 0, 0, 0), 0, none);
      // three weights below one: fourth bone takes the rest; then weights above one and extreme inputs
      add_row(mk(mtsv_pkg::OP_VERTEX, 0, 100000, -50000, 3000, 1000, 2000, -3000, 20000,
                 20000, 20000, 32'hff00ff00), 0, none);
      add_row(mk(mtsv_pkg::OP_VERTEX, 0, -70000, 80000, 90000, -4000, 0, 4000, 30000, 30000,
                 30000, 32'h12ff00ff), 0, none);
      add_row(mk(mtsv_pkg::OP_VERTEX, 0, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff,
                 32'sh80000000, 32'sh7fffffff, 0, 65536, 0, 0, 32'h00000000), 0, none);
      // zero second weight stops the blend
      add_row(mk(mtsv_pkg::OP_VERTEX, 0, 5, 6, 7, 1, 1, 1, 40000, 0, 131071, 32'hffffff00),
              0, none);
      add_row(mk(mtsv_pkg::OP_VERTEX, 0, 65536, 65536, 65536, 0, 65536, 0, 131071, 1, 1,
                 32'h00ff00ff), 0, none);
      add_row(mk(mtsv_pkg::OP_CHAN_WEIGHT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
   endfunction

   function automatic mtsv_pkg::q16_type rnd_q16(int spread);
      case ($urandom_range(0, 9))
         0: return mtsv_pkg::q16_type'($urandom);
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         2: return '0;
         default: return mtsv_pkg::q16_type'(int'($urandom_range(0, 2*spread)) - spread);
      endcase
   endfunction

   function automatic mtsv_pkg::weight_type rnd_weight();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 17'(mtsv_pkg::ONE_Q16);
         2: return 17'($urandom_range(mtsv_pkg::ONE_Q16 + 1, 131071));
         default: return 17'($urandom_range(1, 40000));
      endcase
   endfunction

   function automatic vertex_item_type rnd_vertex();
      vertex_item_type it;
      longint w0, w1, w2;
      bit use_byte [4];
      it = mk(mtsv_pkg::OP_VERTEX, $urandom_range(0, 1023), 0, 0, 0, 0, 0, 0, 0, 0, 0,
              $urandom);
      it.px = rnd_q16(1 << 22);
      it.py = rnd_q16(1 << 22);
      it.pz = rnd_q16(1 << 22);
      it.nx = rnd_q16(1 << 17);
      it.ny = rnd_q16(1 << 17);
      it.nz = rnd_q16(1 << 17);
      it.wa = rnd_weight();
      it.wb = rnd_weight();
      it.wc = rnd_weight();
      w0 = wclamp(it.wa);
      w1 = wclamp(it.wb);
      w2 = wclamp(it.wc);
      use_byte[0] = w0 != 0;
      use_byte[1] = use_byte[0] && w1 != 0;
      use_byte[2] = use_byte[1] && w2 != 0;
      use_byte[3] = use_byte[2] && (w0 + w1 + w2 < mtsv_pkg::ONE_Q16);
      // only blend bones whose four rows are loaded
      for (int b = 0; b < 4; b++)
         if (use_byte[b])
            it.bones[8*b +: 8] = 8'(loaded_bones[$urandom_range(0, loaded_bones.size() - 1)]);
      return it;
   endfunction

   task automatic send_item(vertex_item_type it, bit typed, skinned_vertex_type want);
      int gap;
      int bone;
      bit has;
      skinned_vertex_type r;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_chan.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.op           = it.op;
      req_chan.slot         = it.slot;
      req_chan.px           = it.px;
      req_chan.py           = it.py;
      req_chan.pz           = it.pz;
      req_chan.nx_in        = it.nx;
      req_chan.ny_in        = it.ny;
      req_chan.nz_in        = it.nz;
      req_chan.weight_a     = it.wa;
      req_chan.weight_b     = it.wb;
      req_chan.weight_c     = it.wc;
      req_chan.bone_indices = it.bones;
      req_chan.valid        = 1'b1;
      do @(posedge clock); while (!req_chan.ready);
      has = skin_predict(it, r);
      if (has) pending_vertices.push_back(typed ? want : r);
      case (it.op)
         mtsv_pkg::OP_MAT_ROW: begin
            mat_rows_sent++;
            row_loaded[it.slot] = 1'b1;
            bone = it.slot / 4;
            if (row_loaded[bone*4] && row_loaded[bone*4+1] && row_loaded[bone*4+2] &&
                row_loaded[bone*4+3] && !(bone inside {loaded_bones}))
               loaded_bones.push_back(bone);
         end
         mtsv_pkg::OP_CHAN_WEIGHT: chan_sets_sent++;
         mtsv_pkg::OP_MORPH_DELTA: deltas_sent++;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Result side: random back-pressure, compare against the oldest expected vertex
   initial begin
      int stall;
      skinned_vertex_type exp_v;
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 5);
         if (stall > 0) begin
            rsp_chan.ready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_chan.ready = 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         if (pending_vertices.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result: x=%0d y=%0d z=%0d", rsp_chan.out_x,
                        rsp_chan.out_y, rsp_chan.out_z);
         end else begin
            exp_v = pending_vertices.pop_front();
            vertices_checked++;
            if (rsp_chan.out_x !== exp_v.x || rsp_chan.out_y !== exp_v.y ||
                rsp_chan.out_z !== exp_v.z || rsp_chan.out_nx !== exp_v.nx ||
                rsp_chan.out_ny !== exp_v.ny || rsp_chan.out_nz !== exp_v.nz) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display({"vertex %0d: expected (%0d %0d %0d | %0d %0d %0d)",
                            " got (%0d %0d %0d | %0d %0d %0d)"},
                           vertices_checked, exp_v.x, exp_v.y, exp_v.z, exp_v.nx, exp_v.ny,
                           exp_v.nz, rsp_chan.out_x, rsp_chan.out_y, rsp_chan.out_z,
                           rsp_chan.out_nx, rsp_chan.out_ny, rsp_chan.out_nz);
            end
         end
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   initial begin
      int sent;
      int pick;
      int bone;
      skinned_vertex_type none;
      vertex_item_type it;
      none = '{default: '0};
      reset = 1'b1;
      quiet = 1'b0;
      idle_cycles = 0;
      mismatch_count = 0;
      vertices_checked = 0;
      mat_rows_sent = 0;
      deltas_sent = 0;
      chan_sets_sent = 0;
      req_chan.valid = 1'b0;
      req_chan.op = mtsv_pkg::OP_MAT_ROW;
      req_chan.slot = '0;
      req_chan.px = '0;
      req_chan.py = '0;
      req_chan.pz = '0;
      req_chan.nx_in = '0;
      req_chan.ny_in = '0;
      req_chan.nz_in = '0;
      req_chan.weight_a = '0;
      req_chan.weight_b = '0;
      req_chan.weight_c = '0;
      req_chan.bone_indices = '0;
      foreach (bone_rows[i]) bone_rows[i] = '0;
      foreach (chan_weight[i]) chan_weight[i] = '0;
      foreach (row_loaded[i]) row_loaded[i] = 1'b0;
      for (int i = 0; i < 3; i++) begin
         morph_pos[i] = '0;
         morph_nrm[i] = '0;
      end
      build_directed_table();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // alternate stretches of random gaps with back-to-back traffic
         if (sent % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            // load a whole bone so it can be blended later
            bone = $urandom_range(0, mtsv_pkg::MAX_BONES - 1);
            for (int r = 0; r < 4; r++) begin
               it = mk(mtsv_pkg::OP_MAT_ROW, bone*4 + r, 0, 0, 0, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom);
               it.px = rnd_q16(1 << 17);
               it.py = rnd_q16(1 << 17);
               it.pz = rnd_q16(r == 3 ? 1 << 24 : 1 << 17);
               send_item(it, 0, none);
            end
            sent += 4;
         end else if (pick < 10) begin
            it = mk(mtsv_pkg::OP_MAT_ROW, $urandom_range(0, 1023), $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom);
            send_item(it, 0, none);
            sent++;
         end else if (pick < 25) begin
            it = mk(mtsv_pkg::OP_CHAN_WEIGHT, $urandom_range(0, 9) == 0 ?
                    $urandom_range(16, 1023) : $urandom_range(0, 15), $urandom, $urandom,
                    $urandom, $urandom, $urandom, $urandom, 0, $urandom, $urandom, $urandom);
            it.wa = rnd_weight();
            send_item(it, 0, none);
            sent++;
         end else if (pick < 60) begin
            it = mk(mtsv_pkg::OP_MORPH_DELTA, $urandom_range(0, 9) == 0 ?
                    $urandom_range(16, 1023) : $urandom_range(0, 15), 0, 0, 0, 0, 0, 0,
                    $urandom, $urandom, $urandom, $urandom);
            it.px = rnd_q16(1 << 20);
            it.py = rnd_q16(1 << 20);
            it.pz = rnd_q16(1 << 20);
            it.nx = rnd_q16(1 << 16);
            it.ny = rnd_q16(1 << 16);
            it.nz = rnd_q16(1 << 16);
            send_item(it, 0, none);
            sent++;
         end else begin
            send_item(rnd_vertex(), 0, none);
            sent++;
         end
      end
      req_chan.valid = 1'b0;

      while (pending_vertices.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("checked %0d skinned vertices; sent %0d matrix rows, %0d channel weights",
               vertices_checked, mat_rows_sent, chan_sets_sent);
      $display("%0d deltas, %0d bones fully loaded, %0d mismatching results", deltas_sent,
               loaded_bones.size(), mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
